// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file bbe_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bbe_pkg.sv =====
package bbe_pkg;

  // Geometry
  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int POS_W    = $clog2(MAX_SIDE);
  localparam int DIV_W    = SIDE_W + 1;

  // Field widths
  localparam int PIX_W    = 8;
  localparam int PAD_W    = 12;
  localparam int COUNT_W  = 25;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W   = FRAC_BITS + 1;
  localparam int FCNT_W   = $clog2(FRAC_BITS);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [FRAC_W-1:0]  FRAC_ONE  = {1'b1, {FRAC_BITS{1'b0}}};

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COUNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LABEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_PIXELS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PIXEL_COUNT = 3'd4;

  localparam logic [SIDE_W-1:0] WIDTH_RST  = SIDE_W'(640);
  localparam logic [SIDE_W-1:0] HEIGHT_RST = SIDE_W'(480);
  localparam logic [PIX_W-1:0]  LABEL_RST  = PIX_W'(1);

  // Frame summary handed from the front end to the back end
  typedef struct packed {
    logic [SIDE_W-1:0]  least_x;
    logic [SIDE_W-1:0]  least_y;
    logic [POS_W-1:0]   greatest_x;
    logic [POS_W-1:0]   greatest_y;
    logic [COUNT_W-1:0] count;
    logic [SIDE_W-1:0]  width;
    logic [SIDE_W-1:0]  height;
  } frame_t;

  // One finished result
  typedef struct packed {
    logic               box_found;
    logic [SIDE_W-1:0]  left_edge;
    logic [SIDE_W-1:0]  top_edge;
    logic [SIDE_W-1:0]  right_edge;
    logic [SIDE_W-1:0]  bottom_edge;
    logic [FRAC_W-1:0]  center_x_frac;
    logic [FRAC_W-1:0]  center_y_frac;
    logic [FRAC_W-1:0]  width_frac;
    logic [FRAC_W-1:0]  height_frac;
    logic [COUNT_W-1:0] labeled_count;
  } result_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quot;
  } div_rsp_t;

  // Saturate a programmed side to 1..MAX_SIDE
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/bbe_pix_if.sv =====
interface bbe_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bbe_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

// ===== design/bbe_box_if.sv =====
interface bbe_box_if;
  logic                        valid;
  logic                        ready;
  logic                        box_found;
  logic [bbe_pkg::SIDE_W-1:0]  left_edge;
  logic [bbe_pkg::SIDE_W-1:0]  top_edge;
  logic [bbe_pkg::SIDE_W-1:0]  right_edge;
  logic [bbe_pkg::SIDE_W-1:0]  bottom_edge;
  logic [bbe_pkg::FRAC_W-1:0]  center_x_frac;
  logic [bbe_pkg::FRAC_W-1:0]  center_y_frac;
  logic [bbe_pkg::FRAC_W-1:0]  width_frac;
  logic [bbe_pkg::FRAC_W-1:0]  height_frac;
  logic [bbe_pkg::COUNT_W-1:0] labeled_count;

  modport source (output valid, output box_found, output left_edge, output top_edge,
                  output right_edge, output bottom_edge, output center_x_frac,
                  output center_y_frac, output width_frac, output height_frac,
                  output labeled_count, input ready);
  modport sink   (input valid, input box_found, input left_edge, input top_edge,
                  input right_edge, input bottom_edge, input center_x_frac,
                  input center_y_frac, input width_frac, input height_frac,
                  input labeled_count, output ready);
endinterface

// ===== design/label_bounding_box_extractor.sv =====
// Bounding box of labeled pixels. Label pixels enter on in_pix in raster order, one per
// cycle, with the column and row counted inside the block against frame_width and
// frame_height (each saturated to 1..4096). Pixels equal to target_label are counted and
// their least and greatest x and y tracked; after the last pixel of a frame one result
// leaves on out_box with the padded, clamped corners and the center and size as 1.16
// fractions (65536 is 1.0). If the count does not exceed min_pixel_count only
// labeled_count is nonzero. The pixel front end takes one pixel every cycle; each frame
// summary goes into a two-entry queue, and the result stage works it through one shared
// divider that yields one quotient bit per cycle for four 16-bit quotients. A pixel that
// ends a frame waits only while both queue entries are occupied. There is no clearing
// pass after reset.
module label_bounding_box_extractor (
  input  logic                           clk,
  input  logic                           rst_n,
  bbe_pix_if.sink                        in_pix,
  bbe_box_if.source                      out_box,
  input  logic                           cfg_we,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [bbe_pkg::SIDE_W-1:0]  frame_width_r;
  logic [bbe_pkg::SIDE_W-1:0]  frame_height_r;
  logic [bbe_pkg::PIX_W-1:0]   target_label_r;
  logic [bbe_pkg::PAD_W-1:0]   pad_pixels_r;
  logic [bbe_pkg::COUNT_W-1:0] min_count_r;

  logic            q_push, q_full, q_pop, q_valid;
  bbe_pkg::frame_t q_din, q_dout;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bbe_pkg::WIDTH_RST;
      frame_height_r <= bbe_pkg::HEIGHT_RST;
      target_label_r <= bbe_pkg::LABEL_RST;
      pad_pixels_r   <= '0;
      min_count_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bbe_pkg::CFG_FRAME_WIDTH:     frame_width_r  <= cfg_data[bbe_pkg::SIDE_W-1:0];
        bbe_pkg::CFG_FRAME_HEIGHT:    frame_height_r <= cfg_data[bbe_pkg::SIDE_W-1:0];
        bbe_pkg::CFG_TARGET_LABEL:    target_label_r <= cfg_data[bbe_pkg::PIX_W-1:0];
        bbe_pkg::CFG_PAD_PIXELS:      pad_pixels_r   <= cfg_data[bbe_pkg::PAD_W-1:0];
        bbe_pkg::CFG_MIN_PIXEL_COUNT: min_count_r    <= cfg_data[bbe_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  bbe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix        (in_pix),
    .cfg_width  (frame_width_r),
    .cfg_height (frame_height_r),
    .cfg_label  (target_label_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_din)
  );

  bbe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  bbe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_entry       (q_dout),
    .q_pop         (q_pop),
    .cfg_pad       (pad_pixels_r),
    .cfg_min_count (min_count_r),
    .box           (out_box)
  );

endmodule

// ===== design/bbe_front.sv =====
module bbe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  bbe_pix_if.sink                       pix,
  input  logic [bbe_pkg::SIDE_W-1:0]    cfg_width,
  input  logic [bbe_pkg::SIDE_W-1:0]    cfg_height,
  input  logic [bbe_pkg::PIX_W-1:0]     cfg_label,
  input  logic                          q_full,
  output logic                          q_push,
  output bbe_pkg::frame_t               q_entry
);

  logic [bbe_pkg::POS_W-1:0]   col_r, col_nxt;
  logic [bbe_pkg::POS_W-1:0]   row_r, row_nxt;
  logic [bbe_pkg::SIDE_W-1:0]  least_x_r, least_x_nxt;
  logic [bbe_pkg::SIDE_W-1:0]  least_y_r, least_y_nxt;
  logic [bbe_pkg::POS_W-1:0]   great_x_r, great_x_nxt;
  logic [bbe_pkg::POS_W-1:0]   great_y_r, great_y_nxt;
  logic [bbe_pkg::COUNT_W-1:0] count_r, count_nxt;

  logic [bbe_pkg::SIDE_W-1:0]  w, h;
  logic                        frame_start, hit, col_last, row_last, frame_end, take;
  logic [bbe_pkg::SIDE_W-1:0]  base_lx, base_ly;
  logic [bbe_pkg::POS_W-1:0]   base_gx, base_gy;
  logic [bbe_pkg::COUNT_W-1:0] base_cnt;

  assign w = bbe_pkg::eff_side(cfg_width);
  assign h = bbe_pkg::eff_side(cfg_height);

  // Classify the pixel position against the live frame size
  assign frame_start = (col_r == '0) && (row_r == '0);
  assign col_last    = ({1'b0, col_r} + bbe_pkg::SIDE_W'(1)) >= w;
  assign row_last    = ({1'b0, row_r} + bbe_pkg::SIDE_W'(1)) >= h;
  assign frame_end   = col_last && row_last;
  assign hit         = (pix.pixel_value == cfg_label);

  // Stall only when a finished frame has nowhere to go
  assign pix.ready = !(frame_end && q_full);
  assign take      = pix.valid && pix.ready;

  // Restart the trackers at the first pixel of a frame
  always_comb begin
    if (frame_start) begin
      base_lx  = w;
      base_ly  = h;
      base_gx  = '0;
      base_gy  = '0;
      base_cnt = '0;
    end else begin
      base_lx  = least_x_r;
      base_ly  = least_y_r;
      base_gx  = great_x_r;
      base_gy  = great_y_r;
      base_cnt = count_r;
    end
  end

  // Fold in a matching pixel
  always_comb begin
    least_x_nxt = base_lx;
    least_y_nxt = base_ly;
    great_x_nxt = base_gx;
    great_y_nxt = base_gy;
    count_nxt   = base_cnt;
    if (hit) begin
      if (base_cnt != bbe_pkg::COUNT_MAX) count_nxt = base_cnt + bbe_pkg::COUNT_W'(1);
      if ({1'b0, col_r} < base_lx) least_x_nxt = {1'b0, col_r};
      if ({1'b0, row_r} < base_ly) least_y_nxt = {1'b0, row_r};
      if (col_r > base_gx) great_x_nxt = col_r;
      if (row_r > base_gy) great_y_nxt = row_r;
    end
  end

  // Advance the raster position
  always_comb begin
    col_nxt = col_r + bbe_pkg::POS_W'(1);
    row_nxt = row_r;
    if (col_last) begin
      col_nxt = '0;
      row_nxt = row_last ? '0 : row_r + bbe_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      least_x_r <= bbe_pkg::WIDTH_RST;
      least_y_r <= bbe_pkg::HEIGHT_RST;
      great_x_r <= '0;
      great_y_r <= '0;
      count_r   <= '0;
    end else if (take) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      least_x_r <= least_x_nxt;
      least_y_r <= least_y_nxt;
      great_x_r <= great_x_nxt;
      great_y_r <= great_y_nxt;
      count_r   <= count_nxt;
    end
  end

  // Hand the frame summary to the queue
  assign q_push             = take && frame_end;
  assign q_entry.least_x    = least_x_nxt;
  assign q_entry.least_y    = least_y_nxt;
  assign q_entry.greatest_x = great_x_nxt;
  assign q_entry.greatest_y = great_y_nxt;
  assign q_entry.count      = count_nxt;
  assign q_entry.width      = w;
  assign q_entry.height     = h;

endmodule

// ===== design/bbe_queue.sv =====
module bbe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bbe_pkg::frame_t din,
  output logic            full,
  input  logic            pop,
  output bbe_pkg::frame_t dout,
  output logic            valid
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  bbe_pkg::frame_t      mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_r, rd_r;
  logic [PTR_W:0]       fill_r;

  assign full  = (fill_r == (PTR_W+1)'(DEPTH));
  assign valid = (fill_r != '0);
  assign dout  = mem_r[rd_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + PTR_W'(1);
      if (pop)  rd_r <= rd_r + PTR_W'(1);
      if (push && !pop) begin
        fill_r <= fill_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - (PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== design/bbe_div.sv =====
module bbe_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bbe_pkg::div_req_t req,
  output bbe_pkg::div_rsp_t rsp
);

  logic                         busy_r, done_r, ovf_r;
  logic [bbe_pkg::FCNT_W-1:0]   cnt_r;
  logic [bbe_pkg::DIV_W-1:0]    rem_r, den_r;
  logic [bbe_pkg::FRAC_BITS-1:0] quo_r;
  logic [bbe_pkg::DIV_W:0]      shifted, trial;
  logic                         ge;

  // One quotient bit per cycle, restoring
  assign shifted = {rem_r, 1'b0};
  assign ge      = shifted >= {1'b0, den_r};
  assign trial   = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        // A quotient of one or more clamps at once
        ovf_r <= (req.num >= req.den);
        if (req.num >= req.den) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= bbe_pkg::FCNT_W'(bbe_pkg::FRAC_BITS - 1);
        end
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - bbe_pkg::FCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? trial[bbe_pkg::DIV_W-1:0] : shifted[bbe_pkg::DIV_W-1:0];
      quo_r <= {quo_r[bbe_pkg::FRAC_BITS-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = ovf_r ? bbe_pkg::FRAC_ONE : {1'b0, quo_r};

endmodule

// ===== design/bbe_back.sv =====
module bbe_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  bbe_pkg::frame_t              q_entry,
  output logic                         q_pop,
  input  logic [bbe_pkg::PAD_W-1:0]    cfg_pad,
  input  logic [bbe_pkg::COUNT_W-1:0]  cfg_min_count,
  bbe_box_if.source                    box
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_WAIT   = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  localparam int JOBS  = 4;
  localparam int JOB_W = $clog2(JOBS);
  localparam logic [JOB_W-1:0] JOB_CX = 2'd0;
  localparam logic [JOB_W-1:0] JOB_CY = 2'd1;
  localparam logic [JOB_W-1:0] JOB_DX = 2'd2;
  localparam logic [JOB_W-1:0] JOB_DY = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [JOB_W-1:0]           job_r;
  bbe_pkg::frame_t            frame_r;
  logic                       found_r, found;
  logic [bbe_pkg::SIDE_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [bbe_pkg::SIDE_W-1:0] left_v, top_v, right_v, bottom_v;
  logic [bbe_pkg::FRAC_W-1:0] frac_r [JOBS];
  logic                       out_valid_r, load;
  bbe_pkg::result_t           out_r;
  bbe_pkg::div_req_t          div_req;
  bbe_pkg::div_rsp_t          div_rsp;
  logic [bbe_pkg::SIDE_W-1:0] pad_ext, lo_x, lo_y, hi_x, hi_y, dx, dy;

  bbe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Pad and clamp the corners of the incoming summary
  assign pad_ext = {1'b0, cfg_pad};
  assign found   = q_entry.count > cfg_min_count;
  assign lo_x    = (q_entry.least_x > pad_ext) ? q_entry.least_x - pad_ext : '0;
  assign lo_y    = (q_entry.least_y > pad_ext) ? q_entry.least_y - pad_ext : '0;
  assign hi_x    = {1'b0, q_entry.greatest_x} + pad_ext;
  assign hi_y    = {1'b0, q_entry.greatest_y} + pad_ext;
  assign left_v   = (lo_x > q_entry.width)  ? q_entry.width  : lo_x;
  assign top_v    = (lo_y > q_entry.height) ? q_entry.height : lo_y;
  assign right_v  = (hi_x > q_entry.width)  ? q_entry.width  : hi_x;
  assign bottom_v = (hi_y > q_entry.height) ? q_entry.height : hi_y;

  // Spans of the stored summary, zero when inverted
  assign dx = ({1'b0, frame_r.greatest_x} >= frame_r.least_x) ?
              {1'b0, frame_r.greatest_x} - frame_r.least_x : '0;
  assign dy = ({1'b0, frame_r.greatest_y} >= frame_r.least_y) ?
              {1'b0, frame_r.greatest_y} - frame_r.least_y : '0;

  // Select the operands of the current division
  always_comb begin
    div_req.start = (state_r == ST_LAUNCH);
    case (job_r)
      JOB_CX: begin
        div_req.num = {1'b0, frame_r.least_x} + {2'b0, frame_r.greatest_x};
        div_req.den = {frame_r.width, 1'b0};
      end
      JOB_CY: begin
        div_req.num = {1'b0, frame_r.least_y} + {2'b0, frame_r.greatest_y};
        div_req.den = {frame_r.height, 1'b0};
      end
      JOB_DX: begin
        div_req.num = {1'b0, dx};
        div_req.den = {1'b0, frame_r.width};
      end
      JOB_DY: begin
        div_req.num = {1'b0, dy};
        div_req.den = {1'b0, frame_r.height};
      end
      default: begin
        div_req.num = '0;
        div_req.den = '0;
      end
    endcase
  end

  assign q_pop = (state_r == ST_IDLE) && q_valid;
  assign load  = (state_r == ST_DONE) && (!out_valid_r || box.ready);

  // Sequence the four divisions, or skip them when no box is found
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) state_nxt = found ? ST_LAUNCH : ST_DONE;
      end
      ST_LAUNCH: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) state_nxt = (job_r == JOB_DY) ? ST_DONE : ST_LAUNCH;
      end
      ST_DONE: begin
        if (load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (box.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the summary and collect quotients
  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_r  <= q_entry;
      found_r  <= found;
      job_r    <= JOB_CX;
      left_r   <= found ? left_v   : '0;
      top_r    <= found ? top_v    : '0;
      right_r  <= found ? right_v  : '0;
      bottom_r <= found ? bottom_v : '0;
      for (int i = 0; i < JOBS; i++) frac_r[i] <= '0;
    end else if ((state_r == ST_WAIT) && div_rsp.done) begin
      frac_r[job_r] <= div_rsp.quot;
      job_r         <= job_r + JOB_W'(1);
    end
  end

  // Hold the finished result until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_r.box_found     <= found_r;
      out_r.left_edge     <= left_r;
      out_r.top_edge      <= top_r;
      out_r.right_edge    <= right_r;
      out_r.bottom_edge   <= bottom_r;
      out_r.center_x_frac <= frac_r[JOB_CX];
      out_r.center_y_frac <= frac_r[JOB_CY];
      out_r.width_frac    <= frac_r[JOB_DX];
      out_r.height_frac   <= frac_r[JOB_DY];
      out_r.labeled_count <= frame_r.count;
    end
  end

  assign box.valid         = out_valid_r;
  assign box.box_found     = out_r.box_found;
  assign box.left_edge     = out_r.left_edge;
  assign box.top_edge      = out_r.top_edge;
  assign box.right_edge    = out_r.right_edge;
  assign box.bottom_edge   = out_r.bottom_edge;
  assign box.center_x_frac = out_r.center_x_frac;
  assign box.center_y_frac = out_r.center_y_frac;
  assign box.width_frac    = out_r.width_frac;
  assign box.height_frac   = out_r.height_frac;
  assign box.labeled_count = out_r.labeled_count;

endmodule

// ===== design/bbe_checker.sv =====
`include "assert_macros.svh"

module bbe_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         box_found,
  input  logic [bbe_pkg::SIDE_W-1:0]   left_edge,
  input  logic [bbe_pkg::SIDE_W-1:0]   top_edge,
  input  logic [bbe_pkg::SIDE_W-1:0]   right_edge,
  input  logic [bbe_pkg::SIDE_W-1:0]   bottom_edge,
  input  logic [bbe_pkg::FRAC_W-1:0]   center_x_frac,
  input  logic [bbe_pkg::FRAC_W-1:0]   center_y_frac,
  input  logic [bbe_pkg::FRAC_W-1:0]   width_frac,
  input  logic [bbe_pkg::FRAC_W-1:0]   height_frac,
  input  logic [bbe_pkg::COUNT_W-1:0]  labeled_count
);

  // A stalled request stays valid and keeps its count, left edge and center x
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(labeled_count) && $stable(left_edge) && $stable(center_x_frac), "out request changed while stalled")

  // No box means all geometry reads zero
  `ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && !box_found, left_edge == '0 && top_edge == '0 && right_edge == '0 && bottom_edge == '0 && center_x_frac == '0 && center_y_frac == '0 && width_frac == '0 && height_frac == '0, "geometry set without a box")

  // A found box has ordered corners and at least one pixel
  `ASSERT_IMPLY(a_box_order, clk, rst_n, out_valid && box_found, left_edge <= right_edge && top_edge <= bottom_edge && labeled_count != '0, "found box is inconsistent")

  // Fractions never pass 1.0
  `ASSERT_IMPLY(a_frac_range, clk, rst_n, out_valid, center_x_frac <= bbe_pkg::FRAC_ONE && center_y_frac <= bbe_pkg::FRAC_ONE && width_frac <= bbe_pkg::FRAC_ONE && height_frac <= bbe_pkg::FRAC_ONE, "fraction above 1.0")

endmodule

bind label_bounding_box_extractor bbe_checker u_bbe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_box.valid),
  .out_ready     (out_box.ready),
  .box_found     (out_box.box_found),
  .left_edge     (out_box.left_edge),
  .top_edge      (out_box.top_edge),
  .right_edge    (out_box.right_edge),
  .bottom_edge   (out_box.bottom_edge),
  .center_x_frac (out_box.center_x_frac),
  .center_y_frac (out_box.center_y_frac),
  .width_frac    (out_box.width_frac),
  .height_frac   (out_box.height_frac),
  .labeled_count (out_box.labeled_count)
);
